// ===== rtl/core/lzfd_pkg.sv =====
`timescale 1ns / 1ps
package lzfd_pkg;

   localparam int HIST_DEPTH = 8192;
   localparam int HIST_AW    = $clog2(HIST_DEPTH);
   localparam int OUT_LANES  = 8;
   localparam int LEN_W      = 9;
   localparam int PH_W       = 5;

   localparam logic [HIST_AW-1:0] END_OFFSET  = HIST_AW'(12'h8FF);
   localparam logic [HIST_AW-1:0] SHORT_BASE  = HIST_AW'(256);
   localparam logic [LEN_W-1:0]   NBYTE_BIAS  = LEN_W'(27);
   localparam logic [LEN_W-1:0]   NE_BIAS     = LEN_W'(11);
   localparam logic [LEN_W-1:0]   ND_BIAS     = LEN_W'(7);

   // decode phases
   localparam logic [PH_W-1:0] PH_TOP    = 5'd0;
   localparam logic [PH_W-1:0] PH_LIT    = 5'd1;
   localparam logic [PH_W-1:0] PH_SEL    = 5'd2;
   localparam logic [PH_W-1:0] PH_SH     = 5'd3;
   localparam logic [PH_W-1:0] PH_SB0    = 5'd4;
   localparam logic [PH_W-1:0] PH_SBYTE  = 5'd5;
   localparam logic [PH_W-1:0] PH_SB3    = 5'd6;
   localparam logic [PH_W-1:0] PH_SB2    = 5'd7;
   localparam logic [PH_W-1:0] PH_SB1    = 5'd8;
   localparam logic [PH_W-1:0] PH_LA     = 5'd9;
   localparam logic [PH_W-1:0] PH_LB     = 5'd10;
   localparam logic [PH_W-1:0] PH_LC     = 5'd11;
   localparam logic [PH_W-1:0] PH_LD     = 5'd12;
   localparam logic [PH_W-1:0] PH_LOBYTE = 5'd13;
   localparam logic [PH_W-1:0] PH_OB4    = 5'd14;
   localparam logic [PH_W-1:0] PH_OB3    = 5'd15;
   localparam logic [PH_W-1:0] PH_OB2    = 5'd16;
   localparam logic [PH_W-1:0] PH_OB1    = 5'd17;
   localparam logic [PH_W-1:0] PH_NA     = 5'd18;
   localparam logic [PH_W-1:0] PH_NB     = 5'd19;
   localparam logic [PH_W-1:0] PH_NC     = 5'd20;
   localparam logic [PH_W-1:0] PH_NC1    = 5'd21;
   localparam logic [PH_W-1:0] PH_ND     = 5'd22;
   localparam logic [PH_W-1:0] PH_ND2    = 5'd23;
   localparam logic [PH_W-1:0] PH_ND1    = 5'd24;
   localparam logic [PH_W-1:0] PH_NE     = 5'd25;
   localparam logic [PH_W-1:0] PH_NE4    = 5'd26;
   localparam logic [PH_W-1:0] PH_NE3    = 5'd27;
   localparam logic [PH_W-1:0] PH_NE2    = 5'd28;
   localparam logic [PH_W-1:0] PH_NE1    = 5'd29;
   localparam logic [PH_W-1:0] PH_NBYTE  = 5'd30;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       start_of_stream;
   } lzfd_req_type;

   typedef struct packed {
      logic [7:0] out_byte0;
      logic [7:0] out_byte1;
      logic [7:0] out_byte2;
      logic [7:0] out_byte3;
      logic [7:0] out_byte4;
      logic [7:0] out_byte5;
      logic [7:0] out_byte6;
      logic [7:0] out_byte7;
      logic [3:0] byte_count;
      logic       last_of_run;
      logic       stream_end;
   } lzfd_rsp_type;

   typedef struct packed {
      logic restart;
      logic load;
      logic shift;
   } lzfd_flag_cmd_type;

endpackage

// ===== rtl/core/lzfd_flag.sv =====
`timescale 1ns / 1ps
module lzfd_flag import lzfd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  lzfd_flag_cmd_type cmd,
   input  logic [7:0]        load_byte,
   output logic              bit_out,
   output logic              empty
);

   logic [31:0] word_ff, word_in;
   logic [5:0]  left_ff, left_in;
   logic [1:0]  idx_ff, idx_in;

   always_comb begin
      word_in = word_ff;
      left_in = left_ff;
      idx_in  = idx_ff;
      if (cmd.restart) begin
         word_in = '0;
         left_in = '0;
         idx_in  = '0;
      end else if (cmd.load) begin
         // little-endian assembly of the flag word
         word_in = word_ff | ({24'd0, load_byte} << {idx_ff, 3'b000});
         idx_in  = idx_ff + 2'd1;
         if (idx_ff == 2'd3) begin
            left_in = 6'd32;
         end
      end else if (cmd.shift) begin
         word_in = {word_ff[30:0], 1'b0};
         left_in = left_ff - 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff <= '0;
         left_ff <= '0;
         idx_ff  <= '0;
      end else begin
         word_ff <= word_in;
         left_ff <= left_in;
         idx_ff  <= idx_in;
      end
   end

   assign bit_out = word_ff[31];
   assign empty   = (left_ff == 6'd0);

endmodule

// ===== rtl/core/lzfd_history.sv =====
`timescale 1ns / 1ps
module lzfd_history import lzfd_pkg::*; (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [HIST_AW-1:0] wr_addr,
   input  logic [7:0]         wr_data,
   input  logic               rd_en,
   input  logic [HIST_AW-1:0] rd_addr,
   output logic [7:0]         rd_data
);

   logic [7:0] mem_ff [HIST_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

// ===== rtl/core/lzss_flag_bit_decompressor_core.sv =====
`timescale 1ns / 1ps
// Channel   Ports                        Direction  Carries
// request   req_valid/req_ready/req_data in         one compressed byte, restart mark
// result    rsp_valid/rsp_ready/rsp_data out        up to eight output bytes, count, marks
//
// Each request passes through setup, then one step per flag bit decoded,
// plus a history read and then a write per copied byte; it closes with a
// step that finds no bit left to decode and one that flushes the final group.
// A byte after the end code, without a restart mark, passes through setup only.
// The history memory port sets the copy rate.
// The history needs no clearing after reset: reads before the stream start
// are forced to zero. Reset is synchronous, active high.
// A full output register stalls the sequencer until the result is taken.
module lzss_flag_bit_decompressor_core import lzfd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  lzfd_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output lzfd_rsp_type rsp_data
);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_START   = 3'd1;
   localparam logic [2:0] ST_DATA    = 3'd2;
   localparam logic [2:0] ST_BITS    = 3'd3;
   localparam logic [2:0] ST_COPY_RD = 3'd4;
   localparam logic [2:0] ST_COPY_WR = 3'd5;
   localparam logic [2:0] ST_FLUSH   = 3'd6;

   logic [2:0]          state_ff, state_in;
   lzfd_req_type        req_ff, req_in;
   logic [PH_W-1:0]     phase_ff, phase_in;
   logic [HIST_AW-1:0]  dist_ff, dist_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [HIST_AW-1:0]  wp_ff, wp_in;
   logic                wrapped_ff, wrapped_in;
   logic                finished_ff, finished_in;
   logic                step_end_ff, step_end_in;
   logic                zero_src_ff, zero_src_in;
   logic [7:0]          lanes_ff [OUT_LANES];
   logic [7:0]          lanes_in [OUT_LANES];
   logic [3:0]          cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   lzfd_rsp_type        rsp_data_ff, rsp_data_in;

   lzfd_flag_cmd_type   flag_cmd;
   logic                flag_bit, flag_empty;
   logic                needs_byte;
   logic                put_req, put_ok;
   logic [7:0]          put_val;
   logic                out_free;
   logic                mem_rd_en;
   logic [HIST_AW-1:0]  mem_rd_addr;
   logic [7:0]          mem_rd_data;
   logic [HIST_AW:0]    copy_dist;
   logic [HIST_AW:0]    sb_sum;
   lzfd_rsp_type        lane_pack;

   lzfd_flag u_flag (
      .clock     (clock),
      .reset     (reset),
      .cmd       (flag_cmd),
      .load_byte (req_ff.in_byte),
      .bit_out   (flag_bit),
      .empty     (flag_empty)
   );

   lzfd_history u_history (
      .clock   (clock),
      .wr_en   (put_req && put_ok),
      .wr_addr (wp_ff),
      .wr_data (put_val),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign needs_byte = (phase_ff == PH_LIT) || (phase_ff == PH_SB0) ||
                       (phase_ff == PH_SBYTE) || (phase_ff == PH_LOBYTE) ||
                       (phase_ff == PH_NBYTE);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign put_ok     = (cnt_ff != 4'd8) || out_free;
   assign copy_dist  = {1'b0, dist_ff} + (HIST_AW+1)'(1);
   assign sb_sum     = {1'b0, dist_ff[HIST_AW-2:0], flag_bit} + {1'b0, SHORT_BASE};
   assign mem_rd_addr = wp_ff - copy_dist[HIST_AW-1:0];

   assign lane_pack = '{out_byte0: lanes_ff[0], out_byte1: lanes_ff[1],
                        out_byte2: lanes_ff[2], out_byte3: lanes_ff[3],
                        out_byte4: lanes_ff[4], out_byte5: lanes_ff[5],
                        out_byte6: lanes_ff[6], out_byte7: lanes_ff[7],
                        byte_count: cnt_ff, last_of_run: 1'b0, stream_end: 1'b0};

   // sequencer: decode one flag bit or move one byte per step
   always_comb begin
      state_in    = state_ff;
      req_in      = req_ff;
      phase_in    = phase_ff;
      dist_in     = dist_ff;
      len_in      = len_ff;
      finished_in = finished_ff;
      step_end_in = step_end_ff;
      zero_src_in = zero_src_ff;
      flag_cmd    = '0;
      put_req     = 1'b0;
      put_val     = '0;
      mem_rd_en   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in      = req_data;
               step_end_in = 1'b0;
               state_in    = ST_START;
            end
         end
         ST_START: begin
            // restart drops any partial code, keeps history contents
            if (req_ff.start_of_stream) begin
               flag_cmd.restart = 1'b1;
               phase_in    = PH_TOP;
               dist_in     = '0;
               len_in      = '0;
               finished_in = 1'b0;
            end
            state_in = ST_DATA;
         end
         ST_DATA: begin
            if (finished_ff) begin
               state_in = ST_IDLE;
            end else if (needs_byte) begin
               state_in = ST_BITS;
               case (phase_ff)
                  PH_LIT: begin
                     put_req = 1'b1;
                     put_val = req_ff.in_byte;
                     if (put_ok) begin
                        phase_in = PH_TOP;
                     end else begin
                        state_in = ST_DATA;
                     end
                  end
                  PH_SB0: begin
                     dist_in  = HIST_AW'(req_ff.in_byte);
                     len_in   = LEN_W'(2);
                     state_in = ST_COPY_RD;
                  end
                  PH_SBYTE: begin
                     dist_in  = HIST_AW'(req_ff.in_byte);
                     phase_in = PH_SB3;
                  end
                  PH_LOBYTE: begin
                     dist_in = dist_ff | HIST_AW'(req_ff.in_byte);
                     if (len_ff <= LEN_W'(1)) begin
                        phase_in = PH_OB1;
                     end else if (len_ff == LEN_W'(2)) begin
                        phase_in = PH_OB2;
                     end else if (len_ff == LEN_W'(3)) begin
                        phase_in = PH_OB3;
                     end else begin
                        phase_in = PH_OB4;
                     end
                  end
                  default: begin
                     len_in   = LEN_W'(req_ff.in_byte) + NBYTE_BIAS;
                     state_in = ST_COPY_RD;
                  end
               endcase
            end else begin
               if (flag_empty) begin
                  flag_cmd.load = 1'b1;
               end
               state_in = ST_BITS;
            end
         end
         ST_BITS: begin
            if (!finished_ff && !needs_byte && !flag_empty) begin
               flag_cmd.shift = 1'b1;
               case (phase_ff)
                  PH_TOP: phase_in = flag_bit ? PH_LIT : PH_SEL;
                  PH_SEL: phase_in = flag_bit ? PH_SH : PH_LA;
                  PH_SH:  phase_in = flag_bit ? PH_SBYTE : PH_SB0;
                  PH_SB3, PH_SB2, PH_OB4, PH_OB3, PH_OB2: begin
                     dist_in  = {dist_ff[HIST_AW-2:0], flag_bit};
                     phase_in = phase_ff + 5'd1;
                  end
                  PH_SB1: begin
                     dist_in = sb_sum[HIST_AW-1:0];
                     if (sb_sum[HIST_AW-1:0] >= END_OFFSET) begin
                        finished_in = 1'b1;
                        step_end_in = 1'b1;
                        phase_in    = PH_TOP;
                     end else begin
                        len_in   = LEN_W'(2);
                        state_in = ST_COPY_RD;
                     end
                  end
                  PH_LA: begin
                     if (flag_bit) begin
                        dist_in  = '0;
                        len_in   = LEN_W'(1);
                        phase_in = PH_LOBYTE;
                     end else begin
                        dist_in  = SHORT_BASE;
                        phase_in = PH_LB;
                     end
                  end
                  PH_LB: begin
                     if (flag_bit) begin
                        len_in   = LEN_W'(1);
                        phase_in = PH_LOBYTE;
                     end else begin
                        phase_in = PH_LC;
                     end
                  end
                  PH_LC: begin
                     if (flag_bit) begin
                        len_in   = LEN_W'(2);
                        phase_in = PH_LOBYTE;
                     end else begin
                        phase_in = PH_LD;
                     end
                  end
                  PH_LD: begin
                     len_in   = flag_bit ? LEN_W'(3) : LEN_W'(4);
                     phase_in = PH_LOBYTE;
                  end
                  PH_OB1: begin
                     dist_in  = {dist_ff[HIST_AW-2:0], flag_bit};
                     phase_in = PH_NA;
                  end
                  PH_NA: begin
                     if (flag_bit) begin
                        len_in   = LEN_W'(3);
                        state_in = ST_COPY_RD;
                     end else begin
                        phase_in = PH_NB;
                     end
                  end
                  PH_NB: begin
                     if (flag_bit) begin
                        len_in   = LEN_W'(4);
                        state_in = ST_COPY_RD;
                     end else begin
                        phase_in = PH_NC;
                     end
                  end
                  PH_NC: begin
                     if (flag_bit) begin
                        len_in   = LEN_W'(5);
                        phase_in = PH_NC1;
                     end else begin
                        phase_in = PH_ND;
                     end
                  end
                  PH_NC1: begin
                     len_in   = len_ff + LEN_W'(flag_bit);
                     state_in = ST_COPY_RD;
                  end
                  PH_ND: begin
                     if (flag_bit) begin
                        len_in   = '0;
                        phase_in = PH_ND2;
                     end else begin
                        phase_in = PH_NE;
                     end
                  end
                  PH_ND2: begin
                     len_in   = {len_ff[LEN_W-2:0], flag_bit};
                     phase_in = PH_ND1;
                  end
                  PH_ND1: begin
                     len_in   = {len_ff[LEN_W-2:0], flag_bit} + ND_BIAS;
                     state_in = ST_COPY_RD;
                  end
                  PH_NE: begin
                     if (flag_bit) begin
                        len_in   = '0;
                        phase_in = PH_NE4;
                     end else begin
                        phase_in = PH_NBYTE;
                     end
                  end
                  PH_NE4, PH_NE3, PH_NE2: begin
                     len_in   = {len_ff[LEN_W-2:0], flag_bit};
                     phase_in = phase_ff + 5'd1;
                  end
                  PH_NE1: begin
                     len_in   = {len_ff[LEN_W-2:0], flag_bit} + NE_BIAS;
                     state_in = ST_COPY_RD;
                  end
                  default: phase_in = PH_TOP;
               endcase
            end else begin
               state_in = ST_FLUSH;
            end
         end
         ST_COPY_RD: begin
            // source before stream start reads zero unless history has wrapped
            zero_src_in = !wrapped_ff && ({1'b0, wp_ff} < copy_dist);
            mem_rd_en   = !zero_src_in;
            state_in    = ST_COPY_WR;
         end
         ST_COPY_WR: begin
            put_req = 1'b1;
            put_val = zero_src_ff ? 8'd0 : mem_rd_data;
            if (put_ok) begin
               len_in = len_ff - LEN_W'(1);
               if (len_ff == LEN_W'(1)) begin
                  phase_in = PH_TOP;
                  state_in = ST_BITS;
               end else begin
                  state_in = ST_COPY_RD;
               end
            end
         end
         ST_FLUSH: begin
            if ((cnt_ff == 4'd0) && !step_end_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // output group packer and history write pointer
   always_comb begin
      lanes_in     = lanes_ff;
      cnt_in       = cnt_ff;
      wp_in        = wp_ff;
      wrapped_in   = wrapped_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (state_ff == ST_START && req_ff.start_of_stream) begin
         wp_in      = '0;
         wrapped_in = 1'b0;
      end
      if (put_req && put_ok) begin
         wp_in = wp_ff + HIST_AW'(1);
         if (wp_ff == {HIST_AW{1'b1}}) begin
            wrapped_in = 1'b1;
         end
         if (cnt_ff == 4'd8) begin
            // full group is not the last: hand it over, open a fresh one
            rsp_data_in  = lane_pack;
            rsp_valid_in = 1'b1;
            for (int i = 0; i < OUT_LANES; i++) begin
               lanes_in[i] = '0;
            end
            lanes_in[0] = put_val;
            cnt_in      = 4'd1;
         end else begin
            lanes_in[cnt_ff[2:0]] = put_val;
            cnt_in = cnt_ff + 4'd1;
         end
      end
      if (state_ff == ST_FLUSH && out_free && ((cnt_ff != 4'd0) || step_end_ff)) begin
         rsp_data_in             = lane_pack;
         rsp_data_in.last_of_run = 1'b1;
         rsp_data_in.stream_end  = step_end_ff;
         rsp_valid_in            = 1'b1;
         for (int i = 0; i < OUT_LANES; i++) begin
            lanes_in[i] = '0;
         end
         cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_TOP;
         dist_ff      <= '0;
         len_ff       <= '0;
         wp_ff        <= '0;
         wrapped_ff   <= 1'b0;
         finished_ff  <= 1'b0;
         step_end_ff  <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < OUT_LANES; i++) begin
            lanes_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         dist_ff      <= dist_in;
         len_ff       <= len_in;
         wp_ff        <= wp_in;
         wrapped_ff   <= wrapped_in;
         finished_ff  <= finished_in;
         step_end_ff  <= step_end_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         lanes_ff     <= lanes_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      zero_src_ff <= zero_src_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 4'd8) else $error("group fill count beyond lane count");
   a_empty_is_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.byte_count == 4'd0) |-> rsp_data.stream_end)
      else $error("empty group without end mark");
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.stream_end |-> rsp_data.last_of_run)
      else $error("end mark on a group that is not last");
   a_partial_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.byte_count != 4'd8) |-> rsp_data.last_of_run)
      else $error("short group that is not last");
`endif

endmodule
